// ===== hdl/hpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Handle pool allocator package
// Shared widths, operation and status codes, and the bitmap write request.
// ----------------------------------------------------------------------------
package hpa_pkg;

	localparam int HANDLE_W      = 8;
	localparam int HANDLE_SPACE  = 1 << HANDLE_W;
	localparam int OP_W          = 2;
	localparam int ST_W          = 2;
	localparam int POOL_SIZE_DEF = 256;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_TRY     = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NONE_FREE = 2'd1;
	localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_HELD  = 2'd3;

	typedef struct packed {
		logic                en;
		logic [HANDLE_W-1:0] addr;
		logic                value;
	} map_wr_t;

endpackage

// ===== hdl/hpa_held_map.sv =====
// ----------------------------------------------------------------------------
// Held handle bitmap
// One bit per releasable handle in a synchronous memory, cleared by a sweep
// after reset. Read data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module hpa_held_map import hpa_pkg::*; #(
	parameter int DEPTH = POOL_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [HANDLE_W-1:0] rd_addr,
	output logic                rd_data,
	input  map_wr_t             wr,
	output logic                clearing
);

	localparam int AW = $clog2(DEPTH);

	logic          map_mem [DEPTH];
	logic          clr_q;
	logic [AW-1:0] clr_idx_q;
	logic          rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// The clearing sweep owns the write port until every entry is zero.
	always_ff @(posedge clk) begin
		if (clr_q) begin
			map_mem[clr_idx_q] <= 1'b0;
		end else if (wr.en) begin
			map_mem[wr.addr[AW-1:0]] <= wr.value;
		end
		rd_s1 <= map_mem[rd_addr[AW-1:0]];
	end

	assign rd_data  = rd_s1;
	assign clearing = clr_q;

endmodule

// ===== hdl/handle_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Handle pool allocator
// Hands out handles from a FIFO of released handles, else fresh ones on an
// allocate (not on a try), and checks releases against a held bitmap.
// ----------------------------------------------------------------------------
//  Channel   Ports                                  Transfer
//  request   start, busy, operation, handle         start high and busy low
//  result    done, granted_handle, status           done high, one cycle
//
// The accepting edge reads the free queue and the held bitmap; the next edge
// writes both back and registers the result, raising done, and busy stays
// high until that write-back edge.
// After reset the bitmap is swept to zero, one entry a cycle, over all
// min(POOL_SIZE, 256) entries (256 by default); busy is high meanwhile.
// The receiver cannot stall, so a result never waits.
// ----------------------------------------------------------------------------
module handle_pool_allocator_unit import hpa_pkg::*; #(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     operation,
	input  logic [HANDLE_W-1:0] handle,
	output logic                done,
	output logic [HANDLE_W-1:0] granted_handle,
	output logic [ST_W-1:0]     status
);

	// Only handles that fit the handle field can ever be released or queued.
	localparam int MAP_DEPTH = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;
	localparam int MAW       = $clog2(MAP_DEPTH);
	localparam int QCW       = $clog2(MAP_DEPTH + 1);
	localparam int CW        = $clog2(POOL_SIZE + 1);

	localparam logic [HANDLE_W:0] MAP_DEPTH_V = (HANDLE_W + 1)'(MAP_DEPTH);
	localparam logic [CW-1:0]     POOL_V      = CW'(POOL_SIZE);
	localparam logic [CW-1:0]     MAP_FRESH_V = CW'(MAP_DEPTH);
	localparam logic [QCW-1:0]    QCAP_V      = QCW'(MAP_DEPTH);
	localparam logic [MAW-1:0]    LAST_POS    = MAW'(MAP_DEPTH - 1);

	logic [HANDLE_W-1:0] queue_mem [MAP_DEPTH];

	logic                valid_s1;
	logic [OP_W-1:0]     op_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic [HANDLE_W-1:0] q_rd_s1;
	logic                map_rd;
	logic                clearing;

	logic [MAW-1:0]      head_q;
	logic [MAW-1:0]      tail_q;
	logic [QCW-1:0]      qcount_q;
	logic [CW-1:0]       fresh_q;

	logic                done_q;
	logic [HANDLE_W-1:0] granted_q;
	logic [ST_W-1:0]     status_q;

	logic                accept;
	logic                pop;
	logic                push;
	logic                take_fresh;
	logic                in_range;
	logic [HANDLE_W-1:0] res_handle;
	logic [ST_W-1:0]     res_status;
	map_wr_t             map_wr;
	map_wr_t             map_wr_gated;

	assign busy   = valid_s1 | clearing;
	assign accept = start & ~busy;

	hpa_held_map #(
		.DEPTH(MAP_DEPTH)
	) u_held_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (handle),
		.rd_data  (map_rd),
		.wr       (map_wr_gated),
		.clearing (clearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			handle_s1 <= handle;
		end
	end

	// Queue memory: the head entry is read every cycle; the pointers only move
	// on the write-back edge, so the read taken at acceptance is current.
	always_ff @(posedge clk) begin
		q_rd_s1 <= queue_mem[head_q];
		if (valid_s1 && push) begin
			queue_mem[tail_q] <= handle_s1;
		end
	end

	assign in_range = {1'b0, handle_s1} < MAP_DEPTH_V;

	always_comb begin
		pop        = 1'b0;
		push       = 1'b0;
		take_fresh = 1'b0;
		res_handle = '0;
		res_status = ST_OK;
		map_wr     = '0;
		unique case (op_s1) inside
			OP_ALLOC, OP_TRY: begin
				if (qcount_q != '0) begin
					pop          = 1'b1;
					res_handle   = q_rd_s1;
					map_wr.en    = 1'b1;
					map_wr.addr  = q_rd_s1;
					map_wr.value = 1'b1;
				end else if (op_s1 == OP_TRY) begin
					res_status = ST_NONE_FREE;
				end else if (fresh_q < POOL_V) begin
					take_fresh = 1'b1;
					res_handle = HANDLE_W'(fresh_q);
					// Fresh handles beyond the handle field are never checked.
					if (fresh_q < MAP_FRESH_V) begin
						map_wr.en    = 1'b1;
						map_wr.addr  = HANDLE_W'(fresh_q);
						map_wr.value = 1'b1;
					end
				end else begin
					res_status = ST_EXHAUSTED;
				end
			end
			OP_RELEASE: begin
				if (!in_range || !map_rd) begin
					res_status = ST_NOT_HELD;
				end else begin
					map_wr.en    = 1'b1;
					map_wr.addr  = handle_s1;
					map_wr.value = 1'b0;
					push         = (qcount_q < QCAP_V);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		map_wr_gated    = map_wr;
		map_wr_gated.en = map_wr.en & valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			qcount_q <= '0;
			fresh_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				if (pop) begin
					head_q   <= (head_q == LAST_POS) ? '0 : head_q + 1'b1;
					qcount_q <= qcount_q - 1'b1;
				end
				if (push) begin
					tail_q   <= (tail_q == LAST_POS) ? '0 : tail_q + 1'b1;
					qcount_q <= qcount_q + 1'b1;
				end
				if (take_fresh) begin
					fresh_q <= fresh_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			granted_q <= res_handle;
			status_q  <= res_status;
		end
	end

	assign done           = done_q;
	assign granted_handle = granted_q;
	assign status         = status_q;

	// A result only follows an item that was in flight the cycle before.
	a_done_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result transfer without an item in flight");

	// The free queue never holds more handles than can be released.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcount_q <= QCAP_V)
		else $error("free queue count beyond capacity");

	// A failed result never carries a handle.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> granted_handle == '0)
		else $error("nonzero handle on a failed result");

	// Exhaustion is reported only once every fresh handle is gone and the free queue is empty.
	a_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EXHAUSTED |-> fresh_q == POOL_V && qcount_q == '0)
		else $error("pool exhausted reported with handles left");

endmodule
